/* hdl/tpq_pkg.sv */
// tpq_pkg: shared constants, codes and types for the timer priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

  localparam int DEPTH     = 64;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 8;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 7;

  typedef logic [AW-1:0]    addr_t;
  typedef logic [CW-1:0]    cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_POP    = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } mem_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    status_t status;
    key_t    key;
    tag_t    tag;
    cnt_t    count;
  } result_t;

endpackage

`default_nettype wire

/* hdl/tpq_store.sv */
// tpq_store: entry memory, one write port and one registered read port.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpq_store
  import tpq_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/tpq_cmp.sv */
// tpq_cmp: shared key comparator (less-than and equal) used by the insert walk and the delete search.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpq_cmp
  import tpq_pkg::*;
(
  input  wire key_t a,
  input  wire key_t b,
  output cmp_res_t  res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

/* hdl/tpq_seq.sv */
// tpq_seq: sequencer for insert, peek, pop and delete passes over the store.
// Depends on tpq_pkg; drives tpq_store and reads tpq_cmp.
`timescale 1ns / 1ps
`default_nettype none

module tpq_seq
  import tpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_acc,
  input  wire op_t      in_op,
  input  wire key_t     in_key,
  input  wire tag_t     in_tag,
  input  wire entry_t   rdata,
  input  wire cmp_res_t cmp,
  input  wire logic     res_take,
  output mem_req_t      req,
  output key_t          cmp_key,
  output logic          busy,
  output logic          res_valid,
  output result_t       res
);

  state_t  state_r, state_nxt;
  cnt_t    ptr_r, ptr_nxt;
  cnt_t    occ_r, occ_nxt;
  op_t     op_r, op_nxt;
  key_t    key_r, key_nxt;
  tag_t    tag_r, tag_nxt;
  result_t res_r, res_nxt;

  cnt_t ptr_inc;
  cnt_t ptr_dec;
  logic in_range;
  logic last_shift;
  logic srch_hit;
  logic srch_go;
  logic is_full;

  assign ptr_inc    = ptr_r + cnt_t'(1);
  assign ptr_dec    = ptr_r - cnt_t'(1);
  assign in_range   = (ptr_r < occ_r);
  assign last_shift = (ptr_inc >= occ_r);
  assign srch_hit   = in_range && ((op_r != OP_DELETE) || cmp.eq);
  assign srch_go    = in_range && (op_r == OP_DELETE) && cmp.lt;
  assign is_full    = (occ_r == cnt_t'(DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_INSERT: state_nxt = is_full ? S_DONE : S_INS_RD;
            OP_PEEK,
            OP_POP:    state_nxt = (occ_r == '0) ? S_DONE : S_SRCH_RD;
            OP_DELETE: state_nxt = S_SRCH_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD:   state_nxt = (ptr_r == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP:  state_nxt = cmp.lt ? S_DONE : S_INS_RD;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (srch_hit) begin
          state_nxt = (op_r == OP_PEEK) ? S_DONE : S_SHIFT_RD;
        end else if (srch_go) begin
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = last_shift ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_DONE:     state_nxt = res_take ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ptr_nxt   = ptr_r;
    occ_nxt   = occ_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    res_nxt   = res_r;
    req.we    = 1'b0;
    req.waddr = ptr_r[AW-1:0];
    req.wdata = '{key: key_r, tag: tag_r};
    req.raddr = ptr_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_op;
          key_nxt = in_key;
          tag_nxt = in_tag;
          ptr_nxt = (in_op == OP_INSERT) ? occ_r : '0;
          if (in_op == OP_INSERT) begin
            res_nxt = '{status: ST_FULL, key: in_key, tag: in_tag, count: occ_r};
          end else begin
            res_nxt = '{status: ST_MISS, key: '0, tag: '0, count: occ_r};
          end
        end
      end
      S_INS_RD: begin
        req.raddr = ptr_dec[AW-1:0];
        if (ptr_r == '0) begin
          req.we  = 1'b1;
          occ_nxt = occ_r + cnt_t'(1);
          res_nxt = '{status: ST_OK, key: key_r, tag: tag_r, count: occ_r + cnt_t'(1)};
        end
      end
      S_INS_CMP: begin
        req.we = 1'b1;
        if (cmp.lt) begin
          occ_nxt = occ_r + cnt_t'(1);
          res_nxt = '{status: ST_OK, key: key_r, tag: tag_r, count: occ_r + cnt_t'(1)};
        end else begin
          req.wdata = rdata;
          ptr_nxt   = ptr_dec;
        end
      end
      S_SRCH_CMP: begin
        if (srch_hit) begin
          res_nxt = '{status: ST_OK, key: rdata.key, tag: rdata.tag, count: occ_r};
        end else if (srch_go) begin
          ptr_nxt = ptr_inc;
        end else begin
          res_nxt = '{status: ST_MISS, key: '0, tag: '0, count: occ_r};
        end
      end
      S_SHIFT_RD: begin
        req.raddr = ptr_inc[AW-1:0];
        if (last_shift) begin
          occ_nxt       = occ_r - cnt_t'(1);
          res_nxt.count = occ_r - cnt_t'(1);
        end
      end
      S_SHIFT_WR: begin
        req.we    = 1'b1;
        req.wdata = rdata;
        ptr_nxt   = ptr_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
    tag_r <= tag_nxt;
    res_r <= res_nxt;
  end

  assign cmp_key   = key_r;
  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

/* hdl/timer_priority_queue_core.sv */
// timer_priority_queue_core: top level of the sorted timer queue.
// Depends on tpq_pkg, tpq_store, tpq_cmp and tpq_seq.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_stall   | in_op, in_key, in_tag
//   out     | output    | out_valid/out_stall | out_status, out_key, out_tag, out_count
//
// Each beat (accept to next accept) is set by the single-port walk over the
// entry memory (read an entry, then compare/write it), plus the accept and
// the hand-over of the result. Peek reads only the front entry; pop shifts
// the whole queue; insert walks from the back to the sorted position; delete
// searches from the front and shifts the rest on a hit.
// Full insert and empty peek/pop skip the walk and go straight to the result.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass.
// A result waiting on out_stall does not block the next in beat; only the
// following result waits.
`timescale 1ns / 1ps
`default_nettype none

module timer_priority_queue_core
  import tpq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [KEY_W-1:0]     in_key,
  input  wire logic [TAG_W-1:0]     in_tag,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ST_W-1:0]           out_status,
  output logic [KEY_W-1:0]          out_key,
  output logic [TAG_W-1:0]          out_tag,
  output logic [CNT_OUT_W-1:0]      out_count
);

  mem_req_t req;
  entry_t   rdata;
  cmp_res_t cmp;
  key_t     cmp_key;
  logic     busy;
  logic     res_valid;
  result_t  res;
  logic     in_acc;
  logic     res_take;

  logic                 out_valid_r;
  logic [ST_W-1:0]      out_status_r;
  key_t                 out_key_r;
  tag_t                 out_tag_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // in beat taken only while the sequencer idles
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  tpq_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // one comparator serves the insert walk and the delete search
  tpq_cmp u_cmp (
    .a   (rdata.key),
    .b   (cmp_key),
    .res (cmp)
  );

  tpq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_op     (op_t'(in_op)),
    .in_key    (in_key),
    .in_tag    (in_tag),
    .rdata     (rdata),
    .cmp       (cmp),
    .res_take  (res_take),
    .req       (req),
    .cmp_key   (cmp_key),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= ST_W'(res.status);
      out_key_r    <= res.key;
      out_tag_r    <= res.tag;
      out_count_r  <= CNT_OUT_W'(res.count);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_tag    = out_tag_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

/* hdl/tpq_checker.sv */
// tpq_checker: port-level assertions for timer_priority_queue_core, plus bind.
// Depends on tpq_pkg and timer_priority_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module tpq_checker
  import tpq_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic [OP_W-1:0]      in_op,
  input wire logic [KEY_W-1:0]     in_key,
  input wire logic [TAG_W-1:0]     in_tag,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [ST_W-1:0]      out_status,
  input wire logic [KEY_W-1:0]     out_key,
  input wire logic [TAG_W-1:0]     out_tag,
  input wire logic [CNT_OUT_W-1:0] out_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  // every accepted beat keeps the block busy the next cycle
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accept");

  // full reported only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_count == CNT_OUT_W'(DEPTH))
    else $error("full status below capacity");

  // a miss returns zero key and tag
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS) |-> (out_key == '0) && (out_tag == '0))
    else $error("miss with nonzero payload");

  // no status code beyond full
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_MISS)
      || (out_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind timer_priority_queue_core tpq_checker u_tpq_checker (.*);

`default_nettype wire
